FILE: sv/roi_projection_profile_defines.svh
// Assertion macros for the projection profile checker.
// Needs clk and rst_n in the scope of each use.
`ifndef ROI_PROJECTION_PROFILE_DEFINES_SVH
`define ROI_PROJECTION_PROFILE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rpp_pkg.sv
// Shared types, codes and helpers of the projection profile block.
// No dependencies.
package rpp_pkg;

  localparam int MAX_PROFILE_LENGTH_DEF = 4096;
  localparam int FRACTION_BITS_DEF      = 8;
  localparam int CFG_SIZE_W             = 13;
  localparam int CFG_IDX_W              = 2;
  localparam int ROI_SIZE_LIMIT         = 8191;
  localparam int GRAY_W                 = 8;
  localparam int AVG_W                  = 16;
  localparam int ACTION_W               = 2;
  localparam int PIXEL_W                = 24;
  localparam int INDEX_W                = 12;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PIXEL = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FRAME = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVERAGE_MODE = 2'd0,
    CFG_ROI_WIDTH    = 2'd1,
    CFG_ROI_HEIGHT   = 2'd2,
    CFG_PIXEL_FORMAT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PIXEL_W-1:0]  pixel_value;
    logic [INDEX_W-1:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic [AVG_W-1:0] profile_value;
    logic [AVG_W-1:0] min_value;
    logic [AVG_W-1:0] max_value;
    logic             out_of_range;
  } out_word_t;

  // Gray value of a pixel: low byte, or (11r + 16g + 5b) / 32 rounded down.
  function automatic logic [GRAY_W-1:0] rpp_gray(input logic [PIXEL_W-1:0] px,
                                                 input logic rgb);
    logic [12:0] wsum;
    wsum = 13'(px[23:16]) * 13'd11 + 13'(px[15:8]) * 13'd16 + 13'(px[7:0]) * 13'd5;
    return rgb ? wsum[12:5] : px[7:0];
  endfunction

endpackage

FILE: sv/rpp_stream_if.sv
// Valid/ready stream channel carrying one payload word.
// Payload type is set by the instantiating level (rpp_pkg structs).
interface rpp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
  modport mon    (input valid, input payload, input ready);
endinterface

FILE: sv/rpp_store.sv
// Profile sum store: one write port, one read port, registered read data.
// No dependencies.
module rpp_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 20
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/rpp_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to OUT_W.
// No dependencies.
module rpp_div #(
  parameter int DVD_W = 28,
  parameter int DVS_W = 13,
  parameter int OUT_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [OUT_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial   = {rem_r, q_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    q_nxt   = {q_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r && cnt_r != '0) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = busy_r && (cnt_r == '0);

  generate
    if (DVD_W > OUT_W) begin : g_sat
      assign quotient = (|q_r[DVD_W-1:OUT_W]) ? '1 : q_r[OUT_W-1:0];
    end else begin : g_nosat
      assign quotient = OUT_W'(q_r);
    end
  endgenerate

endmodule

FILE: sv/roi_projection_profile.sv
// Projection profile top level: sequencer, sum store and shared divider.
// Depends on rpp_pkg, rpp_stream_if, rpp_store and rpp_div.
// Pixel word: accept, store read, update. Frame start and unused codes act on
// accept. Read word: the result waits on the bit-serial divider, run three
// times (entry, min, max), then enters the output stage.
// Synchronous active-low reset clears counters, min/max, config registers and
// the output valid flag; the sum store has no reset and needs no clearing pass.
module roi_projection_profile #(
  parameter int MAX_PROFILE_LENGTH = rpp_pkg::MAX_PROFILE_LENGTH_DEF,
  parameter int FRACTION_BITS      = rpp_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpp_pkg::CFG_SIZE_W-1:0] cfg_data,
  rpp_stream_if.sink                     in_chan,
  rpp_stream_if.source                   out_chan
);

  // Largest usable region side: clamp bound, never above what 13 bits hold.
  localparam int SIZE_MAX = (MAX_PROFILE_LENGTH < rpp_pkg::ROI_SIZE_LIMIT) ?
                            MAX_PROFILE_LENGTH : rpp_pkg::ROI_SIZE_LIMIT;
  localparam int POS_W  = $clog2(SIZE_MAX + 1);
  localparam int ADDR_W = $clog2(SIZE_MAX);
  localparam int SUM_W  = $clog2(SIZE_MAX * 255 + 1);
  localparam int DVD_W  = SUM_W + FRACTION_BITS;
  localparam int AVG_W  = rpp_pkg::AVG_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PIX_RD,
    S_PIX_WR,
    S_RD_ADDR,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    OP_ENTRY,
    OP_MIN,
    OP_MAX
  } operand_t;

  // Configuration registers.
  logic                          mode_r;
  logic [rpp_pkg::CFG_SIZE_W-1:0] width_r;
  logic [rpp_pkg::CFG_SIZE_W-1:0] height_r;
  logic                          fmt_r;

  // Sequencer and frame state.
  state_t             state_r, state_nxt;
  operand_t           op_r, op_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic [POS_W-1:0]   row_r, row_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [POS_W-1:0]   fin_r, fin_nxt;
  logic [SUM_W-1:0]   min_r, min_nxt;
  logic [SUM_W-1:0]   max_r, max_nxt;
  logic [rpp_pkg::PIXEL_W-1:0] pix_r, pix_nxt;
  logic [rpp_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  logic [AVG_W-1:0]   q_entry_r, q_entry_nxt;
  logic [AVG_W-1:0]   q_min_r, q_min_nxt;
  logic [AVG_W-1:0]   q_max_r, q_max_nxt;
  logic               out_valid_r, out_valid_nxt;
  rpp_pkg::out_word_t out_word_r, out_word_nxt;

  // Clamped sizes.
  logic [POS_W-1:0] w_clamp, h_clamp, count, length;

  // Pixel update terms.
  logic [rpp_pkg::GRAY_W-1:0] gray;
  logic [POS_W:0]    col_inc, row_inc;
  logic              end_row, last_row, active;
  logic [SUM_W-1:0]  acc_sum, col_sum, fin_sum;
  logic              do_finish;
  logic              in_range;

  // Store and divider hookup.
  logic              st_we;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [SUM_W-1:0]  st_wdata, st_rdata;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_op;
  logic [DVD_W-1:0]  div_dividend;
  logic [AVG_W-1:0]  div_quot;

  // Clamp each side into 1..SIZE_MAX before use.
  function automatic logic [POS_W-1:0] clamp_size(input logic [rpp_pkg::CFG_SIZE_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v == '0) begin
      r = POS_W'(1);
    end else if (32'(v) > SIZE_MAX) begin
      r = POS_W'(SIZE_MAX);
    end else begin
      r = POS_W'(v);
    end
    return r;
  endfunction

  assign w_clamp = clamp_size(width_r);
  assign h_clamp = clamp_size(height_r);
  // Row mode averages over the width; column mode over the height.
  assign count   = mode_r ? h_clamp : w_clamp;
  assign length  = mode_r ? w_clamp : h_clamp;

  assign gray     = rpp_pkg::rpp_gray(pix_r, fmt_r);
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign end_row  = col_inc >= {1'b0, w_clamp};
  assign last_row = row_inc >= {1'b0, h_clamp};
  // Pixels past the last row are dropped until the next frame start.
  assign active   = row_r < h_clamp;
  assign acc_sum  = acc_r + SUM_W'(gray);
  // First row of a column opens the entry; later rows add to what is stored.
  assign col_sum  = (row_r == '0) ? SUM_W'(gray) : st_rdata + SUM_W'(gray);
  assign in_range = (idx_r < fin_r) && (idx_r < length);

  assign st_raddr = (state_r == S_PIX_RD) ? ADDR_W'(col_r) : ADDR_W'(idx_r);

  always_comb begin
    case (op_r)
      OP_ENTRY: div_op = st_rdata;
      OP_MIN:   div_op = min_r;
      OP_MAX:   div_op = max_r;
      default:  div_op = max_r;
    endcase
  end

  // Average in fixed point: sum scaled by the fraction bits, over the count.
  assign div_dividend = DVD_W'(div_op) << FRACTION_BITS;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    acc_nxt       = acc_r;
    fin_nxt       = fin_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    pix_nxt       = pix_r;
    idx_nxt       = idx_r;
    q_entry_nxt   = q_entry_r;
    q_min_nxt     = q_min_r;
    q_max_nxt     = q_max_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    st_we         = 1'b0;
    st_waddr      = ADDR_W'(row_r);
    st_wdata      = acc_sum;
    div_start     = 1'b0;
    do_finish     = 1'b0;
    fin_sum       = acc_sum;

    // Drop the result word once taken.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          case (in_chan.payload.action)
            rpp_pkg::ACT_PIXEL: begin
              pix_nxt   = in_chan.payload.pixel_value;
              state_nxt = S_PIX_RD;
            end
            rpp_pkg::ACT_READ: begin
              idx_nxt   = in_chan.payload.entry_index;
              state_nxt = S_RD_ADDR;
            end
            rpp_pkg::ACT_FRAME: begin
              col_nxt = '0;
              row_nxt = '0;
              acc_nxt = '0;
              fin_nxt = '0;
              min_nxt = '0;
              max_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      S_PIX_RD: state_nxt = S_PIX_WR;

      S_PIX_WR: begin
        state_nxt = S_IDLE;
        if (active) begin
          if (!mode_r) begin
            st_we     = end_row;
            st_waddr  = ADDR_W'(row_r);
            st_wdata  = acc_sum;
            acc_nxt   = end_row ? '0 : acc_sum;
            do_finish = end_row;
            fin_sum   = acc_sum;
          end else begin
            st_we     = 1'b1;
            st_waddr  = ADDR_W'(col_r);
            st_wdata  = col_sum;
            do_finish = last_row;
            fin_sum   = col_sum;
          end
          if (end_row) begin
            col_nxt = '0;
            row_nxt = row_inc[POS_W-1:0];
          end else begin
            col_nxt = col_inc[POS_W-1:0];
          end
          // Fold the finished entry into min/max; hold the count at its bound.
          if (do_finish) begin
            if (fin_r == '0) begin
              min_nxt = fin_sum;
              max_nxt = fin_sum;
            end else begin
              if (fin_sum < min_r) min_nxt = fin_sum;
              if (fin_sum > max_r) max_nxt = fin_sum;
            end
            if (fin_r != POS_W'(SIZE_MAX)) begin
              fin_nxt = fin_r + 1'b1;
            end
          end
        end
      end

      S_RD_ADDR: begin
        op_nxt    = OP_ENTRY;
        state_nxt = S_DIV_GO;
      end

      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          case (op_r)
            OP_ENTRY: begin
              q_entry_nxt = div_quot;
              op_nxt      = OP_MIN;
              state_nxt   = S_DIV_GO;
            end
            OP_MIN: begin
              q_min_nxt = div_quot;
              op_nxt    = OP_MAX;
              state_nxt = S_DIV_GO;
            end
            default: begin
              q_max_nxt = div_quot;
              state_nxt = S_RESULT;
            end
          endcase
        end
      end

      S_RESULT: begin
        // Hold until the output stage is free.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.profile_value = in_range ? q_entry_r : '0;
          out_word_nxt.min_value     = (fin_r != '0) ? q_min_r : '0;
          out_word_nxt.max_value     = (fin_r != '0) ? q_max_r : '0;
          out_word_nxt.out_of_range  = !in_range;
          state_nxt                  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_ENTRY;
      col_r       <= '0;
      row_r       <= '0;
      acc_r       <= '0;
      fin_r       <= '0;
      min_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      width_r     <= rpp_pkg::CFG_SIZE_W'(1);
      height_r    <= rpp_pkg::CFG_SIZE_W'(1);
      fmt_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      acc_r       <= acc_nxt;
      fin_r       <= fin_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rpp_pkg::CFG_AVERAGE_MODE: mode_r   <= cfg_data[0];
          rpp_pkg::CFG_ROI_WIDTH:    width_r  <= cfg_data;
          rpp_pkg::CFG_ROI_HEIGHT:   height_r <= cfg_data;
          rpp_pkg::CFG_PIXEL_FORMAT: fmt_r    <= cfg_data[0];
          default: ;
        endcase
      end
    end
    pix_r      <= pix_nxt;
    idx_r      <= idx_nxt;
    q_entry_r  <= q_entry_nxt;
    q_min_r    <= q_min_nxt;
    q_max_r    <= q_max_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_word_r;

  rpp_store #(
    .DEPTH  (SIZE_MAX),
    .ADDR_W (ADDR_W),
    .DATA_W (SUM_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  rpp_div #(
    .DVD_W (DVD_W),
    .DVS_W (POS_W),
    .OUT_W (AVG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

FILE: sv/rpp_checker.sv
// Port-level checks of the projection profile block, bound to the top level.
// Depends on rpp_pkg and roi_projection_profile_defines.svh.
`include "roi_projection_profile_defines.svh"

module rpp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [rpp_pkg::ACTION_W-1:0]  in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input rpp_pkg::out_word_t            out_word
);

  `RPP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word dropped or changed while stalled")

  `RPP_ASSERT_NEXT(a_busy_after_work, in_valid && in_ready && (in_action == rpp_pkg::ACT_PIXEL || in_action == rpp_pkg::ACT_READ), !in_ready, "input ready while a word is in work")

  `RPP_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(!in_ready), "result word appeared without a read in work")

  `RPP_ASSERT_NOW(a_oor_zero, out_valid && out_word.out_of_range, out_word.profile_value == '0, "flagged entry reads nonzero")

  `RPP_ASSERT_NOW(a_min_le_max, out_valid, out_word.min_value <= out_word.max_value, "minimum average above maximum")

endmodule

bind roi_projection_profile rpp_checker u_rpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_action (in_chan.payload.action),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.payload)
);

FILE: tb/sv/tb_roi_projection_profile.sv
// Self-checking bench for roi_projection_profile: row/column averages of a clipped region.
// Depends on rpp_pkg and rpp_stream_if; predicts every read word and checks it in order.
module tb_roi_projection_profile;
  timeunit 1ns;
  timeprecision 1ps;

  import rpp_pkg::*;

  localparam int unsigned MAX_LEN        = MAX_PROFILE_LENGTH_DEF;
  localparam int unsigned FRAC           = FRACTION_BITS_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 1250;
  // Pixels streamed per extreme-size frame; enough to finish many entries.
  localparam int unsigned EXTREME_PIXELS = 150;
  // Wait after the reads drain; longer than a read takes at the default widths.
  localparam int unsigned SETTLE_CYCLES  = 120;
  localparam int unsigned SQUEEZE_CYCLES = 600;
  localparam int unsigned SQUEEZE_READS  = 16;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned N_DIRECTED     = 18;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [PIXEL_W-1:0]  px;
    logic [INDEX_W-1:0]  idx;
    bit                  pinned;
    out_word_t           want;
  } step_row_t;

  typedef struct {
    bit        pinned;
    out_word_t want;
  } pinned_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_SIZE_W-1:0] cfg_data;

  rpp_stream_if #(.payload_t(in_word_t))  in_if ();
  rpp_stream_if #(.payload_t(out_word_t)) out_if ();

  roi_projection_profile uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Expected read words, oldest first, and the per-word typed-in overrides.
  out_word_t      pending_profiles[$];
  pinned_result_t typed_results[$];
  step_row_t      directed_steps[N_DIRECTED];

  int          errors;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned settings_written;
  int unsigned live_items;
  int unsigned quiet_cycles;
  bit          sender_steady;
  bit          squeeze_req;

  // Shadow of the block: registers, frame counters and the sum store.
  logic        pp_mode;
  logic        pp_rgb;
  logic [12:0] pp_width;
  logic [12:0] pp_height;
  logic [11:0] pp_col;
  logic [12:0] pp_row;
  logic [19:0] pp_row_sum;
  logic [19:0] pp_min;
  logic [19:0] pp_max;
  logic [12:0] pp_done;
  bit   [19:0] pp_sums[MAX_LEN];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Saturate a size register into 1..MAX_LEN.
  function automatic int unsigned fit_size(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_LEN) return MAX_LEN;
    return v;
  endfunction

  // Gray byte straight from the low bits, or (11r + 16g + 5b) / 32.
  function automatic logic [7:0] gray_of(input logic [PIXEL_W-1:0] px, input logic rgb);
    int unsigned r, g, b;
    if (!rgb) return px[7:0];
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    return 8'((11 * r + 16 * g + 5 * b) >> 5);
  endfunction

  // Unsigned 8.8 average, floor(sum * 256 / count), pinned at full scale.
  function automatic logic [AVG_W-1:0] average_of(input logic [19:0] sum,
                                                  input int unsigned count);
    longint unsigned q;
    q = (longint'(sum) << FRAC) / count;
    return (q > 64'hFFFF) ? 16'hFFFF : 16'(q);
  endfunction

  task automatic clear_frame();
    pp_col     = '0;
    pp_row     = '0;
    pp_row_sum = '0;
    pp_done    = '0;
    pp_min     = '0;
    pp_max     = '0;
  endtask

  // Fold a finished entry into the running min/max.
  task automatic close_entry(input logic [19:0] sum);
    if (pp_done == 0) begin
      pp_min = sum;
      pp_max = sum;
    end else begin
      if (sum < pp_min) pp_min = sum;
      if (sum > pp_max) pp_max = sum;
    end
    pp_done = pp_done + 1'b1;
  endtask

  // Advance the shadow by one accepted word; return the read word it causes.
  task automatic project_word(input in_word_t w, output bit has, output out_word_t r);
    int unsigned wd, ht, gray, col, cnt, len;
    logic [19:0] sum;
    has = 1'b0;
    r   = '0;
    case (w.action)
      ACT_PIXEL: begin
        wd = fit_size(pp_width);
        ht = fit_size(pp_height);
        // Drop pixels once every row of the frame is in.
        if (pp_row < ht) begin
          gray = gray_of(w.pixel_value, pp_rgb);
          col  = pp_col;
          if (!pp_mode) begin
            pp_row_sum = pp_row_sum + 20'(gray);
            if (col + 1 >= wd) begin
              if (pp_row < MAX_LEN) pp_sums[pp_row[11:0]] = pp_row_sum;
              close_entry(pp_row_sum);
              pp_row_sum = '0;
            end
          end else begin
            sum = (pp_row == 0) ? 20'(gray) : pp_sums[col] + 20'(gray);
            pp_sums[col] = sum;
            if (pp_row + 1 >= ht) close_entry(sum);
          end
          if (col + 1 >= wd) begin
            pp_col = '0;
            pp_row = pp_row + 1'b1;
          end else begin
            pp_col = 12'(col + 1);
          end
        end
      end
      ACT_FRAME: clear_frame();
      ACT_READ: begin
        if (!pp_mode) begin
          cnt = fit_size(pp_width);
          len = fit_size(pp_height);
        end else begin
          cnt = fit_size(pp_height);
          len = fit_size(pp_width);
        end
        has = 1'b1;
        r.out_of_range = 1'b1;
        if (w.entry_index < pp_done && w.entry_index < len) begin
          r.profile_value = average_of(pp_sums[w.entry_index], cnt);
          r.out_of_range  = 1'b0;
        end
        if (pp_done != 0) begin
          r.min_value = average_of(pp_min, cnt);
          r.max_value = average_of(pp_max, cnt);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: sample both channels and the register port at the rising edge
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    out_word_t      got;
    out_word_t      want;
    out_word_t      pred;
    pinned_result_t pin;
    bit             has;
    bit             active;
    active = 1'b0;
    if (rst_n) begin
      // Check the result first: nothing issued on this edge can answer on it.
      if (out_if.valid && out_if.ready) begin
        active = 1'b1;
        got = out_if.payload;
        if (pending_profiles.size() == 0) begin
          $error("result word with no expectation waiting: 0x%0h", got);
          errors++;
        end else begin
          want = pending_profiles.pop_front();
          compare_field("profile_value", want.profile_value, got.profile_value);
          compare_field("min_value", want.min_value, got.min_value);
          compare_field("max_value", want.max_value, got.max_value);
          compare_field("out_of_range", want.out_of_range, got.out_of_range);
          results_checked++;
        end
      end
      if (in_if.valid && in_if.ready) begin
        active = 1'b1;
        pin = '{1'b0, '0};
        if (typed_results.size() != 0) pin = typed_results.pop_front();
        project_word(in_if.payload, has, pred);
        if (has) pending_profiles.push_back(pin.pinned ? pin.want : pred);
      end
      if (cfg_we) begin
        active = 1'b1;
        case (cfg_index)
          CFG_AVERAGE_MODE: pp_mode   = cfg_data[0];
          CFG_ROI_WIDTH:    pp_width  = cfg_data;
          CFG_ROI_HEIGHT:   pp_height = cfg_data;
          CFG_PIXEL_FORMAT: pp_rgb    = cfg_data[0];
          default: ;
        endcase
      end
    end
    quiet_cycles <= active ? 0 : quiet_cycles + 1;
  end

  // End the run if the block goes silent for too long.
  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_profiles.size());
    $display("tb_roi_projection_profile: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready with runs, gaps and one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int unsigned run_left;
    int unsigned stall_left;
    int unsigned r;
    run_left   = 0;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      // Hold ready low long enough for reads to back up into the input.
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        stall_left  = SQUEEZE_CYCLES;
        run_left    = 1;
      end
      if (stall_left == 0 && run_left == 0) begin
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 6);
        r = $urandom_range(0, 99);
        if (r < 45)      stall_left = 0;
        else if (r < 90) stall_left = $urandom_range(1, 4);
        else             stall_left = $urandom_range(20, 80);
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        run_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return PIXEL_W'($urandom());
    endcase
  endfunction

  // Mostly near the live profile, now and then anywhere in the index range.
  function automatic logic [INDEX_W-1:0] pick_index(input int unsigned len);
    if ($urandom_range(0, 3) == 0) return INDEX_W'($urandom());
    return INDEX_W'($urandom_range(0, (len + 1 > MAX_LEN - 1) ? MAX_LEN - 1 : len + 1));
  endfunction

  // Offer one word at the falling edge and hold it until the block takes it.
  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [PIXEL_W-1:0] px,
                           input logic [INDEX_W-1:0] idx, input bit pinned,
                           input out_word_t want);
    int unsigned gap;
    in_word_t    w;
    gap = sender_steady ? 0 : pick_gap();
    w.action      = act;
    w.pixel_value = px;
    w.entry_index = idx;
    typed_results.push_back('{pinned, want});
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.payload <= w;
    do @(posedge clk); while (!in_if.ready);
    words_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Drain all reads, then let any pixel still in the pipeline retire.
  task automatic settle();
    release_input();
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic mode, input logic [12:0] w_reg,
                              input logic [12:0] h_reg, input logic rgb);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_AVERAGE_MODE;
    cfg_data  <= CFG_SIZE_W'(mode);
    @(negedge clk);
    cfg_index <= CFG_ROI_WIDTH;
    cfg_data  <= w_reg;
    @(negedge clk);
    cfg_index <= CFG_ROI_HEIGHT;
    cfg_data  <= h_reg;
    @(negedge clk);
    cfg_index <= CFG_PIXEL_FORMAT;
    cfg_data  <= CFG_SIZE_W'(rgb);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One frame under one setting: program, restart, stream pixels with reads
  // mixed in, then read back. A nonzero pixel cap cuts the frame short. A rough
  // phase also breaks the sequence: early stop, a restart at a random pixel,
  // stray codes, and a row-mode retune mid-frame.
  task automatic run_phase(input logic mode, input logic [12:0] w_reg,
                           input logic [12:0] h_reg, input logic rgb,
                           input int unsigned read_every, input int unsigned post_reads,
                           input bit rough, input int unsigned pixel_cap);
    int unsigned eff_w, eff_h, length, total, stop_at, p;
    bit          restarted, retuned;
    logic [INDEX_W-1:0] idx;
    eff_w  = fit_size(w_reg);
    eff_h  = fit_size(h_reg);
    length = mode ? eff_w : eff_h;
    total  = eff_w * eff_h;
    settle();
    program_regs(mode, w_reg, h_reg, rgb);
    settings_written++;
    send_word(ACT_FRAME, PIXEL_W'($urandom()), INDEX_W'($urandom()), 1'b0, '0);
    live_items++;
    stop_at = (pixel_cap != 0 && pixel_cap < total) ? pixel_cap : total;
    if (rough && $urandom_range(0, 9) == 0) stop_at = $urandom_range(0, total - 1);
    p         = 0;
    restarted = 1'b0;
    retuned   = 1'b0;
    while (p < stop_at) begin
      if ($urandom_range(1, read_every) == 1) begin
        send_word(ACT_READ, PIXEL_W'($urandom()), pick_index(length), 1'b0, '0);
        live_items++;
      end
      if (rough && $urandom_range(0, 59) == 0)
        send_word(ACT_UNUSED, PIXEL_W'($urandom()), INDEX_W'($urandom()), 1'b0, '0);
      if (rough && !restarted && $urandom_range(0, 149) == 0) begin
        // Drop the frame and start over from the first pixel.
        restarted = 1'b1;
        send_word(ACT_FRAME, PIXEL_W'($urandom()), INDEX_W'($urandom()), 1'b0, '0);
        live_items++;
        p = 0;
      end
      if (rough && !mode && !retuned && p == total / 2 && $urandom_range(0, 4) == 0) begin
        // Retune geometry and format mid-frame; row mode pixels never read the store.
        retuned = 1'b1;
        settle();
        program_regs(1'b0, 13'($urandom_range(1, 12)), 13'($urandom_range(1, 8)),
                     1'($urandom_range(0, 1)));
        settings_written++;
      end
      send_word(ACT_PIXEL, pick_pixel(), INDEX_W'($urandom()), 1'b0, '0);
      live_items++;
      p++;
    end
    // Read back the last entry, the first, then a spread.
    for (int k = 0; k < post_reads; k++) begin
      if (k == 0)      idx = INDEX_W'(length - 1);
      else if (k == 1) idx = '0;
      else             idx = pick_index(length);
      send_word(ACT_READ, PIXEL_W'($urandom()), idx, 1'b0, '0);
      live_items++;
    end
    if (rough) begin
      repeat ($urandom_range(0, 2))
        send_word(ACT_PIXEL, pick_pixel(), INDEX_W'($urandom()), 1'b0, '0);
      if ($urandom_range(0, 3) == 0)
        send_word(ACT_UNUSED, PIXEL_W'($urandom()), INDEX_W'($urandom()), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned start_items;
    int unsigned extreme_words;
    logic        mode;

    // Drive every input from time zero.
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_AVERAGE_MODE;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    errors           = 0;
    words_sent       = 0;
    results_checked  = 0;
    settings_written = 0;
    live_items       = 0;
    quiet_cycles     = 0;
    sender_steady    = 1'b0;
    squeeze_req      = 1'b0;

    // Shadow the reset state: row mode, 1x1 region, gray pixels.
    pp_mode   = 1'b0;
    pp_rgb    = 1'b0;
    pp_width  = 13'd1;
    pp_height = 13'd1;
    clear_frame();

    // Directed words run at the reset setting, so a single pixel finishes the
    // only entry. Fields: action, pixel, index, typed-in, expected word.
    directed_steps = '{
      // Nothing finished after reset: flag the read, report zeros.
      '{ACT_READ,   24'h000000, 12'h000, 1'b1, {16'h0000, 16'h0000, 16'h0000, 1'b1}},
      '{ACT_READ,   24'hFFFFFF, 12'hFFF, 1'b1, {16'h0000, 16'h0000, 16'h0000, 1'b1}},
      // Gray mode keeps the low byte only.
      '{ACT_PIXEL,  24'hFFFFFF, 12'hFFF, 1'b0, '0},
      '{ACT_READ,   24'h000000, 12'h000, 1'b1, {16'hFF00, 16'hFF00, 16'hFF00, 1'b0}},
      '{ACT_READ,   24'h000000, 12'h001, 1'b1, {16'h0000, 16'hFF00, 16'hFF00, 1'b1}},
      // Frame complete: this pixel is dropped.
      '{ACT_PIXEL,  24'h000000, 12'h000, 1'b0, '0},
      '{ACT_READ,   24'h000000, 12'h000, 1'b1, {16'hFF00, 16'hFF00, 16'hFF00, 1'b0}},
      // Unused action code: no result, no state change.
      '{ACT_UNUSED, 24'hABCDEF, 12'hFFF, 1'b0, '0},
      '{ACT_READ,   24'h000000, 12'hFFF, 1'b1, {16'h0000, 16'hFF00, 16'hFF00, 1'b1}},
      // New frame clears the finished count and min/max.
      '{ACT_FRAME,  24'hFFFFFF, 12'hFFF, 1'b0, '0},
      '{ACT_READ,   24'h000000, 12'h000, 1'b1, {16'h0000, 16'h0000, 16'h0000, 1'b1}},
      '{ACT_PIXEL,  24'h000100, 12'h000, 1'b0, '0},
      '{ACT_READ,   24'h000000, 12'h000, 1'b1, {16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{ACT_FRAME,  24'h000000, 12'h000, 1'b0, '0},
      '{ACT_PIXEL,  24'h000080, 12'h000, 1'b0, '0},
      '{ACT_READ,   24'hFFFFFF, 12'h000, 1'b1, {16'h8000, 16'h8000, 16'h8000, 1'b0}},
      '{ACT_READ,   24'h000000, 12'hFFF, 1'b1, {16'h0000, 16'h8000, 16'h8000, 1'b1}},
      '{ACT_UNUSED, 24'h000000, 12'h000, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i])
      send_word(directed_steps[i].act, directed_steps[i].px, directed_steps[i].idx,
                directed_steps[i].pinned, directed_steps[i].want);

    // Extreme sizes, large frames cut short: saturated height in row mode,
    // saturated width in column mode, and zero sizes clamped up to one.
    extreme_words = words_sent;
    run_phase(1'b0, 13'd3,    13'd8191, 1'b1, 16, 4, 1'b0, EXTREME_PIXELS);
    run_phase(1'b1, 13'd4097, 13'd1,    1'b0, 16, 6, 1'b0, EXTREME_PIXELS);
    run_phase(1'b1, 13'd8191, 13'd0,    1'b1, 16, 4, 1'b0, EXTREME_PIXELS);
    run_phase(1'b0, 13'd0,    13'd0,    1'b0, 4,  3, 1'b0, 0);
    extreme_words = words_sent - extreme_words;

    // Back-pressure: stall the receiver while reads keep coming, back to back.
    squeeze_req   = 1'b1;
    sender_steady = 1'b1;
    repeat (SQUEEZE_READS)
      send_word(ACT_READ, PIXEL_W'($urandom()), INDEX_W'($urandom()), 1'b0, '0);
    sender_steady = 1'b0;

    // Random frames, mostly small and well formed.
    start_items = live_items;
    while (live_items - start_items < RANDOM_ITEMS) begin
      mode = 1'($urandom_range(0, 1));
      sender_steady = ($urandom_range(0, 3) == 0);
      run_phase(mode,
                ($urandom_range(0, 19) == 0) ? 13'd0 :
                ($urandom_range(0, 5) == 0) ? 13'($urandom_range(11, 40)) :
                                              13'($urandom_range(1, 10)),
                ($urandom_range(0, 19) == 0) ? 13'd0 :
                ($urandom_range(0, 9) == 0) ? 13'($urandom_range(9, 24)) :
                                              13'($urandom_range(1, 8)),
                1'($urandom_range(0, 1)), 6, $urandom_range(2, 6), 1'b1, 0);
    end
    sender_steady = 1'b0;

    // Drain: wait out the last reads, then the pipeline depth.
    release_input();
    while (pending_profiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_profiles.size() != 0) begin
      $error("%0d expected results never arrived", pending_profiles.size());
      errors++;
    end

    $display("Run covered %0d words (%0d in extreme-size frames), %0d checked reads, %0d settings",
             words_sent, extreme_words, results_checked, settings_written);
    $display("over row/column modes, gray/RGB, size clamping, retunes and output stalls.");
    if (errors == 0) begin
      $display("tb_roi_projection_profile: done, clean");
    end else begin
      $display("tb_roi_projection_profile: done, errors");
    end
    $finish;
  end

endmodule

FILE: roi_projection_profile.f
+incdir+sv
sv/rpp_pkg.sv
sv/rpp_stream_if.sv
sv/rpp_store.sv
sv/rpp_div.sv
sv/roi_projection_profile.sv
sv/rpp_checker.sv
tb/sv/tb_roi_projection_profile.sv
